// ===== rtl/core/swm_pkg.sv =====
// Shared types and constants for the sliding window maximum unit.
package swm_pkg;

    // Width of a sample word on the ports and of the window size register.
    localparam int SAMPLE_WIDTH = 32;
    localparam int CFG_WIDTH    = 7;

    // Input word: one sample and its end-of-array flag.
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_value;
        logic                           end_of_array;
    } t_swm_in;

    // Output word: the window maximum and the last-window flag.
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] max_value;
        logic                           is_last;
    } t_swm_out;

    // Control broadcast to every cell of the candidate chain.
    typedef struct packed {
        logic step;   // take a new sample this cycle
        logic shift;  // front candidate leaves, everything moves one cell forward
        logic clear;  // empty the chain after this cycle
    } t_swm_cell_ctl;

endpackage

// ===== rtl/core/swm_cell.sv =====
// One candidate cell of the monotonic chain: value, age and valid flag.
module swm_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int AGE_WIDTH  = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swm_pkg::t_swm_cell_ctl        i_ctl,
    input  logic signed [DATA_WIDTH-1:0]  i_sample,
    input  logic                          i_prev_src_keep,
    input  logic                          i_nb_valid,
    input  logic                          i_nb_keep,
    input  logic signed [DATA_WIDTH-1:0]  i_nb_value,
    input  logic [AGE_WIDTH-1:0]          i_nb_age,
    output logic                          o_valid,
    output logic signed [DATA_WIDTH-1:0]  o_value,
    output logic [AGE_WIDTH-1:0]          o_age,
    output logic                          o_keep,
    output logic                          o_src_keep
);

    logic                         r_valid;
    logic signed [DATA_WIDTH-1:0] r_value;
    logic [AGE_WIDTH-1:0]         r_age;
    logic                         n_valid;
    logic signed [DATA_WIDTH-1:0] n_value;
    logic [AGE_WIDTH-1:0]         n_age;
    logic                         src_valid;
    logic signed [DATA_WIDTH-1:0] src_value;
    logic [AGE_WIDTH-1:0]         src_age;

    // A candidate survives the new sample only if it is strictly larger.
    assign o_keep = r_valid && (r_value > i_sample);

    // When the front expires, this position is filled from the next cell.
    assign o_src_keep = i_ctl.shift ? i_nb_keep : o_keep;
    assign src_valid  = i_ctl.shift ? i_nb_valid : r_valid;
    assign src_value  = i_ctl.shift ? i_nb_value : r_value;
    assign src_age    = i_ctl.shift ? i_nb_age : r_age;

    // Next content: empty on clear; on a sample keep a survivor, take the new sample at the first
    // free position, or fall empty; on a shift alone take the next cell's content.
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_age   = r_age;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
            n_age   = '0;
        end else if (i_ctl.step) begin
            if (o_src_keep) begin
                n_valid = 1'b1;
                n_value = src_value;
                n_age   = src_age + AGE_WIDTH'(1);
            end else if (i_prev_src_keep) begin
                n_valid = 1'b1;
                n_value = i_sample;
                n_age   = '0;
            end else begin
                n_valid = 1'b0;
                n_age   = '0;
            end
        end else if (i_ctl.shift) begin
            n_valid = src_valid;
            n_value = src_value;
            n_age   = src_age;
        end
    end

    // Control state is reset; the stored value needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
        end else begin
            r_valid <= n_valid;
            r_age   <= n_age;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_age   = r_age;

endmodule

// ===== rtl/core/sliding_window_maximum_unit.sv =====
// Top level of the sliding window maximum unit: candidate chain, window control and output stage.
//
// The unit takes one signed sample word per cycle when not stalled and, once the current array
// holds at least window_size samples, returns one word per sample with the maximum of the last
// window_size samples. Candidates sit in a chain of WINDOW_MAX cells, oldest at the front;
// every cell compares itself with the new sample in the same cycle, so a sample is taken
// every clock while no trim pass runs and the output register is free or being drained; the
// result is registered and appears in the cycle after acceptance. A word flagged end_of_array
// gives the last window, marked is_last, and empties the chain. After a write of the window
// size the input stalls while each candidate too old for the new window is shifted out of the
// front, one per cycle, and through a last check in which the front is seen to fit. A window
// size of 0 counts as 1 and one above WINDOW_MAX counts as WINDOW_MAX.
module sliding_window_maximum_unit #(
    parameter int WINDOW_MAX = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  swm_pkg::t_swm_in                 i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output swm_pkg::t_swm_out                o_out_word,
    input  logic                             i_cfg_we,
    input  logic [swm_pkg::CFG_WIDTH-1:0]    i_cfg_wdata
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int KW = $clog2(WINDOW_MAX + 1);
    localparam int SW = swm_pkg::SAMPLE_WIDTH;

    logic [swm_pkg::CFG_WIDTH-1:0] r_window;
    logic                          r_purge;
    logic                          n_purge;
    logic [KW-1:0]                 r_fill;
    logic [KW-1:0]                 n_fill;
    logic [KW-1:0]                 fill_inc;
    logic                          r_out_valid;
    logic                          n_out_valid;
    swm_pkg::t_swm_out             r_out;
    swm_pkg::t_swm_out             n_out;

    logic [31:0]                   k_wide;
    logic [KW-1:0]                 win_k;
    logic                          accept;
    logic                          front_expire;
    logic                          front_stale;
    swm_pkg::t_swm_cell_ctl        ctl;
    logic signed [DATA_WIDTH-1:0]  sample;
    logic signed [DATA_WIDTH-1:0]  front_next;
    logic [SW-1:0]                 front_out;

    logic                          w_valid    [0:WINDOW_MAX];
    logic                          w_keep     [0:WINDOW_MAX];
    logic                          w_src_keep [0:WINDOW_MAX];
    logic signed [DATA_WIDTH-1:0]  w_value    [0:WINDOW_MAX];
    logic [AW-1:0]                 w_age      [0:WINDOW_MAX];

    // Sample taken at the internal width: truncated or zero-extended.
    generate
        if (DATA_WIDTH > SW) begin : g_in_wide
            assign sample = {{(DATA_WIDTH-SW){1'b0}}, i_in_word.sample_value};
        end else begin : g_in_narrow
            assign sample = i_in_word.sample_value[DATA_WIDTH-1:0];
        end
    endgenerate

    // Effective window size, clamped to the range of the chain.
    always_comb begin
        if (r_window == '0) begin
            k_wide = 32'd1;
        end else if (32'(r_window) > 32'(WINDOW_MAX)) begin
            k_wide = 32'(WINDOW_MAX);
        end else begin
            k_wide = 32'(r_window);
        end
    end
    assign win_k = k_wide[KW-1:0];

    // The front candidate leaves with this sample, or is already too old after a
    // window change.
    assign front_expire = w_valid[0] && ((32'(w_age[0]) + 32'd1) >= 32'(win_k));
    assign front_stale  = w_valid[0] && (32'(w_age[0]) >= 32'(win_k));

    // Input handshake: stalled while old candidates are trimmed or the output is full.
    assign o_in_ready = !r_purge && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    // Chain control.
    always_comb begin
        ctl.step  = accept;
        ctl.clear = accept && i_in_word.end_of_array;
        if (accept) begin
            ctl.shift = front_expire;
        end else begin
            ctl.shift = r_purge && front_stale;
        end
    end

    // Trim pass runs after a window write until the front fits the window.
    always_comb begin
        n_purge = r_purge;
        if (i_cfg_we) begin
            n_purge = 1'b1;
        end else if (r_purge && !front_stale) begin
            n_purge = 1'b0;
        end
    end

    // Tie-off beyond the last cell; the position before the first always accepts.
    assign w_valid[WINDOW_MAX]    = 1'b0;
    assign w_keep[WINDOW_MAX]     = 1'b0;
    assign w_value[WINDOW_MAX]    = '0;
    assign w_age[WINDOW_MAX]      = '0;
    assign w_src_keep[WINDOW_MAX] = 1'b0;

    // Candidate chain.
    generate
        for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
            logic prev_src_keep;
            if (gi == 0) begin : g_first
                assign prev_src_keep = 1'b1;
            end else begin : g_rest
                assign prev_src_keep = w_src_keep[gi-1];
            end
            swm_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .AGE_WIDTH  (AW)
            ) u_cell (
                .i_clk           (i_clk),
                .i_rst_n         (i_rst_n),
                .i_ctl           (ctl),
                .i_sample        (sample),
                .i_prev_src_keep (prev_src_keep),
                .i_nb_valid      (w_valid[gi+1]),
                .i_nb_keep       (w_keep[gi+1]),
                .i_nb_value      (w_value[gi+1]),
                .i_nb_age        (w_age[gi+1]),
                .o_valid         (w_valid[gi]),
                .o_value         (w_value[gi]),
                .o_age           (w_age[gi]),
                .o_keep          (w_keep[gi]),
                .o_src_keep      (w_src_keep[gi])
            );
        end
    endgenerate

    // The new front after this sample is the window maximum.
    always_comb begin
        if (w_src_keep[0]) begin
            front_next = front_expire ? w_value[1] : w_value[0];
        end else begin
            front_next = sample;
        end
    end

    // Window maximum brought to the port width: low bits, or zero-extended.
    generate
        if (DATA_WIDTH >= SW) begin : g_out_wide
            assign front_out = front_next[SW-1:0];
        end else begin : g_out_narrow
            assign front_out = SW'(unsigned'(front_next));
        end
    endgenerate

    // Fill count of the current array, saturating at the chain length.
    assign fill_inc = (32'(r_fill) < 32'(WINDOW_MAX)) ? (r_fill + KW'(1)) : r_fill;

    always_comb begin
        n_fill = r_fill;
        if (accept) begin
            n_fill = i_in_word.end_of_array ? '0 : fill_inc;
        end
    end

    // Output register: loaded on a sample that completes a window.
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (accept && (fill_inc >= win_k)) begin
            n_out_valid     = 1'b1;
            n_out.max_value = front_out;
            n_out.is_last   = i_in_word.end_of_array;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= swm_pkg::CFG_WIDTH'(1);
            r_purge     <= 1'b0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            r_purge     <= n_purge;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
